@@ hw/rtl/skt_pkg.sv @@
// Shared types, codes and default sizes for the sorted key table lookup block.
package skt_pkg;

    // Default table geometry
    localparam int DEF_CAPACITY   = 256;
    localparam int DEF_NUM_TABLES = 4;

    // Fixed field widths
    localparam int KEY_W  = 16;
    localparam int VAL_W  = 32;
    localparam int CMD_W  = 2;
    localparam int SEL_W  = 2;
    localparam int TIU_W  = 3;
    localparam int STAT_W = 2;
    localparam int ENTRY_W = KEY_W + VAL_W;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_LOOKUP = 2'd2
    } t_cmd;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } t_status;

    // One command as taken from the input stream
    typedef struct packed {
        t_cmd              cmd;
        logic [SEL_W-1:0]  sel;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
    } t_req;

    // Result flags, packed as carried on the output tuser (found in bit 0)
    typedef struct packed {
        t_status status;
        logic    found;
    } t_res_flags;

endpackage

@@ hw/rtl/skt_mem.sv @@
// Single-port-write, single-port-read entry memory with registered read data.
module skt_mem
    import skt_pkg::*;
#(
    parameter int DEPTH  = DEF_CAPACITY * DEF_NUM_TABLES,
    parameter int ADDR_W = $clog2(DEF_CAPACITY * DEF_NUM_TABLES),
    parameter int DATA_W = ENTRY_W
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/skt_seq.sv @@
// Command sequencer: per-table counts, shared key compare/address unit, memory control.
module skt_seq
    import skt_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int NUM_TABLES = DEF_NUM_TABLES,
    parameter int CNT_W      = $clog2(DEF_CAPACITY + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [TIU_W-1:0] i_tables_in_use,
    input  logic             i_start,
    input  t_req             i_req,
    input  logic             i_res_ready,
    output logic             o_idle,
    output logic             o_done,
    output t_res_flags       o_flags,
    output logic [VAL_W-1:0] o_value,
    output logic [CNT_W-1:0] o_count
);

    localparam int DEPTH  = NUM_TABLES * CAPACITY;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TSEL_W = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_DISPATCH = 6'b000010,
        S_LOOK     = 6'b000100,
        S_SHIFT    = 6'b001000,
        S_PLACE    = 6'b010000,
        S_DONE     = 6'b100000
    } t_state;

    t_state               r_state, n_state;
    t_req                 r_req, n_req;
    logic [ADDR_W-1:0]    r_base, n_base;
    logic [CNT_W-1:0]     r_n, n_n;
    logic [CNT_W-1:0]     r_lo, n_lo;
    logic [CNT_W-1:0]     r_hi1, n_hi1;
    logic [CNT_W-1:0]     r_probe, n_probe;
    logic [CNT_W-1:0]     r_j, n_j;
    logic                 r_found, n_found;
    logic [VAL_W-1:0]     r_val, n_val;
    t_status              r_status, n_status;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [CNT_W-1:0]     r_cnt [NUM_TABLES];

    logic                 cnt_we;
    logic [CNT_W-1:0]     cnt_wval;
    logic [TSEL_W-1:0]    sel_idx;
    logic                 sel_bad;

    logic                 mem_we, mem_re;
    logic [CNT_W-1:0]     w_idx, rd_idx;
    logic [ADDR_W-1:0]    mem_waddr, mem_raddr;
    logic [ENTRY_W-1:0]   mem_wdata, mem_rdata;
    logic [KEY_W-1:0]     rd_key;
    logic [VAL_W-1:0]     rd_val;

    logic                 key_lt, key_eq, key_gt;
    logic [CNT_W-1:0]     nxt_lo, nxt_hi1, nxt_probe, probe0, j_dec;
    logic [CNT_W:0]       probe_sum;

    assign sel_idx = TSEL_W'(r_req.sel);
    assign sel_bad = ({1'b0, r_req.sel} >= i_tables_in_use) || (int'(r_req.sel) >= NUM_TABLES);

    assign rd_key = mem_rdata[KEY_W-1:0];
    assign rd_val = mem_rdata[ENTRY_W-1:KEY_W];

    // Shared compare unit: request key against the entry read last cycle
    assign key_lt = r_req.key < rd_key;
    assign key_eq = r_req.key == rd_key;
    assign key_gt = rd_key > r_req.key;

    // Next search window and midpoint probe
    assign nxt_lo    = key_lt ? r_lo : CNT_W'(r_probe + CNT_W'(1));
    assign nxt_hi1   = key_lt ? r_probe : r_hi1;
    assign probe_sum = {1'b0, nxt_lo} + {1'b0, nxt_hi1} - (CNT_W + 1)'(1);
    assign nxt_probe = CNT_W'(probe_sum >> 1);
    assign probe0    = CNT_W'(r_n - CNT_W'(1)) >> 1;
    assign j_dec     = CNT_W'(r_j - CNT_W'(1));

    // Address generation
    assign mem_waddr = r_base + ADDR_W'(w_idx);
    assign mem_raddr = r_base + ADDR_W'(rd_idx);

    // Sequencer next state
    always_comb begin
        n_state  = r_state;
        n_req    = r_req;
        n_base   = r_base;
        n_n      = r_n;
        n_lo     = r_lo;
        n_hi1    = r_hi1;
        n_probe  = r_probe;
        n_j      = r_j;
        n_found  = r_found;
        n_val    = r_val;
        n_status = r_status;
        n_count  = r_count;
        cnt_we   = 1'b0;
        cnt_wval = r_n;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        w_idx    = r_j;
        rd_idx   = r_probe;
        mem_wdata = {r_req.value, r_req.key};

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_req   = i_req;
                    n_base  = ADDR_W'(TSEL_W'(i_req.sel) * CAPACITY);
                    n_n     = r_cnt[TSEL_W'(i_req.sel)];
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_found  = 1'b0;
                n_val    = '0;
                n_status = ST_OK;
                n_count  = r_n;
                n_state  = S_DONE;
                if (sel_bad) begin
                    n_status = ST_INVALID;
                    n_count  = '0;
                end else begin
                    case (r_req.cmd)
                        CMD_CLEAR: begin
                            n_count  = '0;
                            cnt_we   = 1'b1;
                            cnt_wval = '0;
                        end
                        CMD_INSERT: begin
                            if (r_n >= CAPACITY) begin
                                n_status = ST_FULL;
                            end else if (r_n == '0) begin
                                mem_we   = 1'b1;
                                w_idx    = '0;
                                n_count  = CNT_W'(1);
                                cnt_we   = 1'b1;
                                cnt_wval = CNT_W'(1);
                            end else begin
                                mem_re  = 1'b1;
                                rd_idx  = CNT_W'(r_n - CNT_W'(1));
                                n_j     = r_n;
                                n_state = S_SHIFT;
                            end
                        end
                        CMD_LOOKUP: begin
                            if (r_n == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_lo    = '0;
                                n_hi1   = r_n;
                                n_probe = probe0;
                                mem_re  = 1'b1;
                                rd_idx  = probe0;
                                n_state = S_LOOK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // One probe per cycle: compare, narrow, read the next midpoint
            S_LOOK: begin
                if (key_eq) begin
                    n_found = 1'b1;
                    n_val   = rd_val;
                    n_state = S_DONE;
                end else begin
                    n_lo  = nxt_lo;
                    n_hi1 = nxt_hi1;
                    if (nxt_lo < nxt_hi1) begin
                        n_probe = nxt_probe;
                        mem_re  = 1'b1;
                        rd_idx  = nxt_probe;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            // One shift per cycle: move entry j-1 up to j while its key is larger
            S_SHIFT: begin
                w_idx  = r_j;
                mem_we = 1'b1;
                if (key_gt) begin
                    mem_wdata = mem_rdata;
                    n_j       = j_dec;
                    if (j_dec == '0) begin
                        n_state = S_PLACE;
                    end else begin
                        mem_re = 1'b1;
                        rd_idx = CNT_W'(j_dec - CNT_W'(1));
                    end
                end else begin
                    n_count  = CNT_W'(r_n + CNT_W'(1));
                    cnt_we   = 1'b1;
                    cnt_wval = CNT_W'(r_n + CNT_W'(1));
                    n_state  = S_DONE;
                end
            end
            S_PLACE: begin
                mem_we   = 1'b1;
                w_idx    = r_j;
                n_count  = CNT_W'(r_n + CNT_W'(1));
                cnt_we   = 1'b1;
                cnt_wval = CNT_W'(r_n + CNT_W'(1));
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            for (int t = 0; t < NUM_TABLES; t++) begin
                r_cnt[t] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (cnt_we) begin
                r_cnt[sel_idx] <= cnt_wval;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_base   <= n_base;
        r_n      <= n_n;
        r_lo     <= n_lo;
        r_hi1    <= n_hi1;
        r_probe  <= n_probe;
        r_j      <= n_j;
        r_found  <= n_found;
        r_val    <= n_val;
        r_status <= n_status;
        r_count  <= n_count;
    end

    skt_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (ENTRY_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_idle         = (r_state == S_IDLE);
    assign o_done         = (r_state == S_DONE) && i_res_ready;
    assign o_flags.found  = r_found;
    assign o_flags.status = r_status;
    assign o_value        = r_val;
    assign o_count        = r_count;

`ifndef NO_ASSERTIONS
    // New commands only arrive while the sequencer is idle
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == S_IDLE))
        else $error("start while busy");

    // Search window is never empty and the probe lies inside it
    a_probe_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK) |-> (r_lo < r_hi1) && (r_probe >= r_lo) && (r_probe < r_hi1))
        else $error("probe outside search window");

    // Writes never land beyond the current fill of the table
    a_write_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (w_idx <= r_n) && (r_n < CAPACITY))
        else $error("table write out of range");

    // A table count never exceeds its capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt_we |-> (cnt_wval <= CNT_W'(CAPACITY)))
        else $error("table count overflow");
`endif

endmodule

@@ hw/rtl/sorted_key_table_lookup.sv @@
// Sorted key tables: clear, ordered insert and binary-search lookup over one shared entry memory.
// Lookup: binary search, at most log2(count)+1 probes.
// Insert: entries with larger keys shift up one place, then the new entry is written.
// One command at a time; the rate is set by the single memory read port, one probe per cycle.
// Reset (synchronous, active low) empties every table and sets tables_in_use to zero.
// Entry memory is not cleared; only entries below a table's count are ever read.
module sorted_key_table_lookup
    import skt_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int NUM_TABLES = DEF_NUM_TABLES,
    parameter int CNT_W      = $clog2(CAPACITY + 1),
    parameter int OUT_DATA_W = ((VAL_W + CNT_W + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration: tables_in_use
    input  logic                  i_cfg_wr_en,
    input  logic [TIU_W-1:0]      i_cfg_wr_data,
    // Command stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [47:0]           i_s_tdata,   // key[15:0], value_in[47:16]
    input  logic [3:0]            i_s_tuser,   // command[1:0], table_select[3:2]
    // Result stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,   // value_out[31:0], entry_count above, zero fill
    output logic [2:0]            o_m_tuser    // found[0], status[2:1]
);

    logic [TIU_W-1:0]      r_tiu;
    logic                  r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;
    t_res_flags            r_m_user;

    logic                  seq_idle, seq_done, res_ready, s_accept;
    t_req                  s_req;
    t_res_flags            seq_flags;
    logic [VAL_W-1:0]      seq_value;
    logic [CNT_W-1:0]      seq_count;

    // Input beat unpacking
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign s_req.cmd   = t_cmd'(i_s_tuser[1:0]);
    assign s_req.sel   = i_s_tuser[3:2];
    assign s_req.key   = i_s_tdata[15:0];
    assign s_req.value = i_s_tdata[47:16];
    assign o_s_tready  = seq_idle;

    // Result slot free when empty or draining this cycle
    assign res_ready = !r_m_valid || i_m_tready;

    // Config register and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tiu     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_tiu <= i_cfg_wr_data;
            end
            if (seq_done) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Output beat register
    always_ff @(posedge i_clk) begin
        if (seq_done) begin
            r_m_data <= OUT_DATA_W'({seq_count, seq_value});
            r_m_user <= seq_flags;
        end
    end

    skt_seq #(
        .CAPACITY   (CAPACITY),
        .NUM_TABLES (NUM_TABLES),
        .CNT_W      (CNT_W)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_tables_in_use (r_tiu),
        .i_start         (s_accept),
        .i_req           (s_req),
        .i_res_ready     (res_ready),
        .o_idle          (seq_idle),
        .o_done          (seq_done),
        .o_flags         (seq_flags),
        .o_value         (seq_value),
        .o_count         (seq_count)
    );

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;

endmodule

@@ sim/sorted_key_table_lookup_tb.sv @@
// Self-checking testbench for sorted_key_table_lookup: directed and random streams against a table tracker.
`timescale 1ns / 1ps

module sorted_key_table_lookup_tb;
    import skt_pkg::*;

    localparam int CNT_W          = $clog2(DEF_CAPACITY + 1);
    localparam int OUT_W          = ((VAL_W + CNT_W + 7) / 8) * 8;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int RX_HOLD_CYCLES = 400;
    localparam logic [SEL_W-1:0] FILL_TABLE = 2'd2;

    // Command code the block leaves unused
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // Expected outcome of one command
    typedef struct {
        logic              found;
        logic [VAL_W-1:0]  value;
        t_status           status;
        logic [CNT_W-1:0]  count;
    } t_lookup_outcome;

    // Shadow copy of the tables plus the queue of outcomes still owed by the block
    class t_key_table_tracker;
        logic [KEY_W-1:0] keys [DEF_NUM_TABLES][DEF_CAPACITY];
        logic [VAL_W-1:0] vals [DEF_NUM_TABLES][DEF_CAPACITY];
        int               counts [DEF_NUM_TABLES];
        int               tables_in_use;
        int               mismatches;
        t_lookup_outcome  pending_results[$];

        function new();
            foreach (counts[i]) counts[i] = 0;
            tables_in_use = 0;
            mismatches = 0;
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH @%0t: %s", $time, msg);
            mismatches++;
        endtask

        // Apply one accepted command to the shadow tables and queue its outcome
        function void note_command(logic [CMD_W-1:0] cmd, logic [SEL_W-1:0] sel,
                                   logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
            t_lookup_outcome r;
            int n, j, lo, hi, probe;
            r.found = 1'b0;
            r.value = '0;
            r.status = ST_OK;
            r.count = '0;
            if (int'(sel) >= tables_in_use || int'(sel) >= DEF_NUM_TABLES) begin
                r.status = ST_INVALID;
            end else begin
                n = counts[sel];
                case (cmd)
                    CMD_CLEAR: begin
                        n = 0;
                    end
                    CMD_INSERT: begin
                        if (n >= DEF_CAPACITY) begin
                            r.status = ST_FULL;
                        end else begin
                            // shift larger keys up; equal keys stay below the new one
                            j = n;
                            while (j > 0 && keys[sel][j-1] > key) begin
                                keys[sel][j] = keys[sel][j-1];
                                vals[sel][j] = vals[sel][j-1];
                                j--;
                            end
                            keys[sel][j] = key;
                            vals[sel][j] = value;
                            n++;
                        end
                    end
                    CMD_LOOKUP: begin
                        if (n == 0) begin
                            r.status = ST_EMPTY;
                        end else begin
                            // binary search that stops at the first matching probe
                            lo = 0;
                            hi = n - 1;
                            do begin
                                probe = (lo + hi) / 2;
                                if (key < keys[sel][probe]) hi = probe - 1;
                                else lo = probe + 1;
                            end while (key != keys[sel][probe] && lo <= hi);
                            if (key == keys[sel][probe]) begin
                                r.found = 1'b1;
                                r.value = vals[sel][probe];
                            end
                        end
                    end
                    default: ;
                endcase
                counts[sel] = n;
                r.count = n[CNT_W-1:0];
            end
            pending_results.push_back(r);
        endfunction

        // Compare one result beat against the oldest outcome
        task check_result(logic [OUT_W-1:0] tdata, logic [2:0] tuser);
            t_lookup_outcome r;
            t_res_flags flags;
            flags = t_res_flags'(tuser);
            if (pending_results.size() == 0) begin
                report_mismatch("result beat with nothing outstanding");
                return;
            end
            r = pending_results.pop_front();
            if (flags.found !== r.found)
                report_mismatch($sformatf("found %0b, want %0b", flags.found, r.found));
            if (tdata[VAL_W-1:0] !== r.value)
                report_mismatch($sformatf("value_out %h, want %h", tdata[VAL_W-1:0], r.value));
            if (flags.status !== r.status)
                report_mismatch($sformatf("status %0d, want %0d", flags.status, r.status));
            if (tdata[VAL_W +: CNT_W] !== r.count)
                report_mismatch($sformatf("entry_count %0d, want %0d",
                                          tdata[VAL_W +: CNT_W], r.count));
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [TIU_W-1:0]     cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [47:0]          s_tdata     = '0;
    logic [3:0]           s_tuser     = '0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [OUT_W-1:0]     m_tdata;
    logic [2:0]           m_tuser;

    t_key_table_tracker sb;
    int snd_idle_pct  = 0;
    int rcv_idle_pct  = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    sorted_key_table_lookup dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_s_tvalid    (s_tvalid),
        .o_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),   // key[15:0], value_in[47:16]
        .i_s_tuser     (s_tuser),   // command[1:0], table_select[3:2]
        .o_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .o_m_tdata     (m_tdata),   // value_out[31:0], entry_count[40:32]
        .o_m_tuser     (m_tuser)    // found[0], status[2:1]
    );

    // 100 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result side: random stalls, long hold-offs on request, check every beat
    always @(posedge i_clk) begin
        if (hold_requests != hold_served) begin
            hold_served <= hold_requests;
            hold_left   <= RX_HOLD_CYCLES;
            m_tready    <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
        if (i_rst_n && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    end

    // Watchdog: too long without any beat on either side
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one command beat and wait for it to be taken
    task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [SEL_W-1:0] sel,
                             input logic [KEY_W-1:0] key, input logic [VAL_W-1:0] value);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {value, key};
        s_tuser  <= {sel, cmd};
        do @(posedge i_clk); while (!s_tready);
        sb.note_command(cmd, sel, key, value);
    endtask

    // Write tables_in_use once the block has drained
    task automatic write_tables_in_use(input logic [TIU_W-1:0] v);
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        sb.tables_in_use = int'(v);
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin snd_idle_pct = 26; rcv_idle_pct = 64; end
            1: begin snd_idle_pct = 64; rcv_idle_pct = 26; end
            default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
        endcase
    endtask

    // Keys: extremes, a narrow band for duplicates, or anything
    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return '1;
            2, 3, 4, 5, 6, 7: return KEY_W'($urandom_range(0, 31));
            default: return KEY_W'($urandom);
        endcase
    endfunction

    // One random command, mostly aimed at live tables
    task automatic send_random_item(input int tiu);
        int live, r, n;
        logic [CMD_W-1:0] cmd;
        logic [SEL_W-1:0] sel;
        logic [KEY_W-1:0] key;
        live = (tiu > DEF_NUM_TABLES) ? DEF_NUM_TABLES : tiu;
        if (live > 0 && $urandom_range(0, 9) != 0) sel = SEL_W'($urandom_range(0, live - 1));
        else sel = SEL_W'($urandom_range(0, 3));
        r = $urandom_range(0, 99);
        if (r < 2) cmd = CMD_CLEAR;
        else if (r < 45) cmd = CMD_INSERT;
        else if (r < 97) cmd = CMD_LOOKUP;
        else cmd = CMD_UNUSED;
        n = sb.counts[sel];
        if (cmd == CMD_LOOKUP && n > 0 && $urandom_range(0, 1) == 1)
            key = sb.keys[sel][$urandom_range(0, n - 1)];
        else
            key = pick_key();
        send_beat(cmd, sel, key, $urandom);
    endtask

    initial begin
        int tiu_list [7] = '{4, 2, 7, 1, 3, 0, 4};
        int len_list [7] = '{270, 270, 270, 270, 270, 40, 270};
        int mode_list[7] = '{0, 0, 1, 1, 2, 2, 2};
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // No tables registered: everything is invalid
        set_idling(0);
        write_tables_in_use(3'd0);
        send_beat(CMD_LOOKUP, 2'd0, 16'h1234, 32'h0);
        send_beat(CMD_UNUSED, 2'd3, 16'h0, 32'h0);
        send_beat(CMD_INSERT, 2'd1, 16'hFFFF, 32'hFFFF_FFFF);

        // Directed: empty, extremes, duplicates, hit and miss, unused code, clear
        write_tables_in_use(3'd4);
        send_beat(CMD_LOOKUP, 2'd0, 16'h0000, 32'h0);
        send_beat(CMD_UNUSED, 2'd0, 16'hFFFF, 32'hFFFF_FFFF);
        send_beat(CMD_CLEAR,  2'd1, 16'h0, 32'h0);
        send_beat(CMD_INSERT, 2'd0, 16'h8000, 32'hFFFF_FFFF);
        send_beat(CMD_INSERT, 2'd0, 16'h0000, 32'h0000_0000);
        send_beat(CMD_INSERT, 2'd0, 16'hFFFF, 32'hA5A5_A5A5);
        send_beat(CMD_INSERT, 2'd0, 16'h8000, 32'h1234_5678);
        send_beat(CMD_INSERT, 2'd0, 16'h8000, 32'h5A5A_5A5A);
        send_beat(CMD_LOOKUP, 2'd0, 16'h8000, 32'h0);
        send_beat(CMD_LOOKUP, 2'd0, 16'h0000, 32'h0);
        send_beat(CMD_LOOKUP, 2'd0, 16'hFFFF, 32'h0);
        send_beat(CMD_LOOKUP, 2'd0, 16'h7FFF, 32'h0);
        send_beat(CMD_UNUSED, 2'd0, 16'h0, 32'h0);
        send_beat(CMD_INSERT, 2'd3, 16'hFFFF, 32'h8000_0001);
        send_beat(CMD_LOOKUP, 2'd3, 16'hFFFF, 32'h0);
        send_beat(CMD_LOOKUP, 2'd3, 16'h0000, 32'h0);
        send_beat(CMD_CLEAR,  2'd0, 16'h0, 32'h0);
        send_beat(CMD_LOOKUP, 2'd0, 16'h8000, 32'h0);
        send_beat(CMD_LOOKUP, 2'd2, 16'h0001, 32'h0);
        send_beat(CMD_INSERT, 2'd2, 16'h0001, 32'h7FFF_FFFF);

        // Random phases over several table counts and idling patterns
        for (int p = 0; p < 7; p++) begin
            write_tables_in_use(TIU_W'(tiu_list[p]));
            set_idling(mode_list[p]);
            if (p == 0 || p == 4) hold_requests <= hold_requests + 1;
            for (int i = 0; i < len_list[p]; i++) send_random_item(tiu_list[p]);

            // Fill one table past capacity, then search it
            if (p == 2) begin
                write_tables_in_use(3'd4);
                send_beat(CMD_CLEAR, FILL_TABLE, 16'h0, 32'h0);
                for (int i = 0; i < DEF_CAPACITY + 6; i++)
                    send_beat(CMD_INSERT, FILL_TABLE, pick_key(), $urandom);
                for (int i = 0; i < 12; i++)
                    send_beat(CMD_LOOKUP, FILL_TABLE,
                              (i % 3 == 0) ? pick_key()
                                           : sb.keys[FILL_TABLE][$urandom_range(0, DEF_CAPACITY - 1)],
                              32'h0);
            end
        end

        // Drain and settle
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ sorted_key_table_lookup.f @@
hw/rtl/skt_pkg.sv
hw/rtl/skt_mem.sv
hw/rtl/skt_seq.sv
hw/rtl/sorted_key_table_lookup.sv
sim/sorted_key_table_lookup_tb.sv
